>>> sv/toba_pkg.sv
// Shared types and constants for the OHLCV time bar aggregator.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
package toba_pkg;

  localparam int unsigned SymbolsDef = 64;
  localparam int unsigned MaskW      = 64;
  localparam int unsigned SymW       = 6;
  localparam int unsigned TsW        = 64;
  localparam int unsigned PxW        = 48;
  localparam int unsigned BarPxW     = 47;
  localparam int unsigned VolW       = 63;
  localparam int unsigned CntW       = 32;
  localparam int unsigned SeqW       = 64;
  localparam int unsigned PaddrW     = 4;

  localparam logic [TsW-1:0] Len1 = 64'd60000;
  localparam logic [TsW-1:0] Len5 = 64'd300000;
  localparam int unsigned Rem1W = 16;
  localparam int unsigned Rem5W = 19;

  typedef enum logic [1:0] {
    ST_BAR   = 2'd0,
    ST_BAD   = 2'd1,
    ST_UNSUP = 2'd2
  } status_e;

  typedef struct packed {
    logic [TsW-1:0]    start;
    logic [BarPxW-1:0] open;
    logic [BarPxW-1:0] high;
    logic [BarPxW-1:0] low;
    logic [BarPxW-1:0] close;
    logic [VolW-1:0]   vol;
    logic [CntW-1:0]   cnt;
    logic [TsW-1:0]    first;
    logic [TsW-1:0]    latest;
  } bar_t;

  typedef struct packed {
    logic capture;
    logic count;
    logic div_start;
    logic rd;
    logic upd;
    logic sel;
    logic emit_rej;
    logic emit_cur;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic unsup;
    logic div_done;
  } sts_t;

endpackage

>>> sv/toba_rem.sv
// Remainder unit: timestamp modulo one-minute and five-minute lengths.
// Residue folding, reciprocal multiply, back-multiply; depends on toba_pkg.
`timescale 1ns / 1ps
module toba_rem (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [toba_pkg::TsW-1:0] ts_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [toba_pkg::Rem1W-1:0] rem1_o,
  output logic [toba_pkg::Rem5W-1:0] rem5_o
);
  import toba_pkg::*;

  // both lengths are 32 * odd divisor; low 5 bits pass straight through
  localparam int unsigned LoW = 5;
  localparam int unsigned XW  = 31;
  localparam int unsigned PW  = 63;
  localparam int unsigned N1  = 42;
  localparam int unsigned N5  = 45;
  localparam int unsigned Q1W = PW - N1;
  localparam int unsigned Q5W = PW - N5;
  localparam int unsigned R1W = Rem1W - LoW;
  localparam int unsigned R5W = Rem5W - LoW;

  localparam logic [XW-1:0] D1 = XW'(Len1 >> LoW);
  localparam logic [XW-1:0] D5 = XW'(Len5 >> LoW);
  // 2^16, 2^32, 2^48 modulo each divisor
  localparam logic [XW-1:0] K1A = 31'd1786;
  localparam logic [XW-1:0] K2A = 31'd421;
  localparam logic [XW-1:0] K3A = 31'd31;
  localparam logic [XW-1:0] K1B = 31'd9286;
  localparam logic [XW-1:0] K2B = 31'd7921;
  localparam logic [XW-1:0] K3B = 31'd7531;
  // ceil(2^N / D), exact for folded sums below 2^31
  localparam logic [PW-1:0] M1 = 63'd2345624806;
  localparam logic [PW-1:0] M5 = 63'd3752999690;

  logic [TsW-LoW-1:0] t;
  logic [XW-1:0]      c0, c1, c2, c3;
  logic [XW-1:0]      x1_d, x5_d, x1_q, x5_q;
  logic [LoW-1:0]     lo_q;
  logic [PW-1:0]      p1, p5;
  logic [Q1W-1:0]     q1_q;
  logic [Q5W-1:0]     q5_q;
  logic [XW-1:0]      d1, d5;
  logic [R1W-1:0]     r1_q;
  logic [R5W-1:0]     r5_q;
  logic               v1_q, v2_q, done_q;

  assign t  = ts_i[TsW-1:LoW];
  assign c0 = XW'(t[15:0]);
  assign c1 = XW'(t[31:16]);
  assign c2 = XW'(t[47:32]);
  assign c3 = XW'(t[TsW-LoW-1:48]);
  assign x1_d = c0 + c1 * K1A + c2 * K2A + c3 * K3A;
  assign x5_d = c0 + c1 * K1B + c2 * K2B + c3 * K3B;
  assign p1 = PW'(x1_q) * M1;
  assign p5 = PW'(x5_q) * M5;
  assign d1 = x1_q - XW'(q1_q) * D1;
  assign d5 = x5_q - XW'(q5_q) * D5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x1_q <= x1_d;
      x5_q <= x5_d;
      lo_q <= ts_i[LoW-1:0];
    end
    if (v1_q) begin
      q1_q <= p1[PW-1:N1];
      q5_q <= p5[PW-1:N5];
    end
    if (v2_q) begin
      r1_q <= d1[R1W-1:0];
      r5_q <= d5[R5W-1:0];
    end
  end

  assign busy_o = v1_q || v2_q;
  assign done_o = done_q;
  assign rem1_o = {r1_q, lo_q};
  assign rem5_o = {r5_q, lo_q};

endmodule

>>> sv/toba_ctrl.sv
// Sequencer for one trade: check, then a reject report or remainder, two bar updates, two reports.
// Depends on toba_pkg.
`timescale 1ns / 1ps
module toba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  toba_pkg::sts_t sts_i,
  output toba_pkg::cmd_t cmd_o,
  output logic           busy_o
);
  import toba_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CHK  = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_RD0  = 9'b000001000,
    S_UPD0 = 9'b000010000,
    S_RD1  = 9'b000100000,
    S_UPD1 = 9'b001000000,
    S_EM0  = 9'b010000000,
    S_EM1  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.bad || sts_i.unsup) begin
          cmd_o.emit_rej = 1'b1;
          cmd_o.last     = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.count     = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: if (sts_i.div_done) state_d = S_RD0;
      S_RD0: begin
        cmd_o.rd = 1'b1;
        state_d = S_UPD0;
      end
      S_UPD0: begin
        cmd_o.upd = 1'b1;
        state_d = S_RD1;
      end
      S_RD1: begin
        cmd_o.rd  = 1'b1;
        cmd_o.sel = 1'b1;
        state_d = S_UPD1;
      end
      S_UPD1: begin
        cmd_o.upd = 1'b1;
        cmd_o.sel = 1'b1;
        state_d = S_EM0;
      end
      S_EM0: begin
        cmd_o.emit_cur = 1'b1;
        state_d = S_EM1;
      end
      S_EM1: begin
        cmd_o.emit_cur = 1'b1;
        cmd_o.sel      = 1'b1;
        cmd_o.last     = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> sv/toba_dp.sv
// Datapath: trade capture, field checks, bar memory, bar fold and result register.
// Depends on toba_pkg and toba_rem.
`timescale 1ns / 1ps
module toba_dp #(
  parameter int unsigned SYMBOLS = toba_pkg::SymbolsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  toba_pkg::cmd_t              cmd_i,
  output toba_pkg::sts_t              sts_o,
  input  logic [toba_pkg::MaskW-1:0]  mask_i,
  input  logic [toba_pkg::SymW-1:0]   symbol_index_i,
  input  logic                        ids_present_i,
  input  logic [toba_pkg::TsW-1:0]    timestamp_ms_i,
  input  logic signed [toba_pkg::PxW-1:0] price_i,
  input  logic signed [toba_pkg::PxW-1:0] volume_i,
  output logic                        res_valid_o,
  output logic [1:0]                  status_o,
  output logic                        interval_sel_o,
  output logic                        finalized_o,
  output toba_pkg::bar_t              bar_o,
  output logic [toba_pkg::SeqW-1:0]   update_sequence_o,
  output logic                        last_o
);
  import toba_pkg::*;

  localparam int unsigned Depth = 2 * SYMBOLS;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [SymW-1:0]  sym_q;
  logic             ids_q;
  logic [TsW-1:0]   ts_q;
  logic [PxW-1:0]   px_q, vol_q;
  logic [SeqW-1:0]  seq_q;
  bar_t             mem [Depth];
  bar_t             rd_q;
  logic [Depth-1:0] valid_q;
  bar_t             cur_q [2];
  logic             res_valid_q, int_q, fin_q, last_q;
  logic [1:0]       status_q;
  bar_t             res_q;

  logic [Rem1W-1:0] rem1;
  logic [Rem5W-1:0] rem5;
  logic             rem_busy, rem_done;
  logic [AW-1:0]    addr;
  logic [TsW-1:0]   tstart;
  logic             ov, roll, fresh, same;
  bar_t             nb;
  logic [BarPxW-1:0] p47, v47;
  logic [VolW:0]    vsum;

  toba_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .ts_i    (ts_q),
    .busy_o  (rem_busy),
    .done_o  (rem_done),
    .rem1_o  (rem1),
    .rem5_o  (rem5)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sym_q <= symbol_index_i;
      ids_q <= ids_present_i;
      ts_q  <= timestamp_ms_i;
      px_q  <= price_i;
      vol_q <= volume_i;
    end
  end

  assign sts_o.bad = !ids_q || (px_q == '0) || px_q[PxW-1] || vol_q[PxW-1];
  assign sts_o.unsup = (32'(sym_q) >= SYMBOLS) || !mask_i[sym_q];
  assign sts_o.div_done = rem_done;

  assign addr = AW'({1'b0, sym_q, cmd_i.sel});
  assign tstart = cmd_i.sel ? ts_q - TsW'(rem5) : ts_q - TsW'(rem1);
  assign p47 = px_q[BarPxW-1:0];
  assign v47 = vol_q[BarPxW-1:0];
  assign vsum = {1'b0, rd_q.vol} + (VolW + 1)'(v47);

  always_comb begin
    ov    = valid_q[addr];
    roll  = ov && (rd_q.start < tstart);
    fresh = !ov || roll;
    same  = ov && (rd_q.start == tstart);
    nb    = rd_q;
    if (fresh) begin
      nb.start  = tstart;
      nb.open   = p47;
      nb.high   = p47;
      nb.low    = p47;
      nb.close  = p47;
      nb.vol    = VolW'(v47);
      nb.cnt    = CntW'(1);
      nb.first  = ts_q;
      nb.latest = ts_q;
    end else if (same) begin
      if (p47 > rd_q.high) nb.high = p47;
      if (p47 < rd_q.low) nb.low = p47;
      nb.vol = vsum[VolW] ? '1 : vsum[VolW-1:0];
      if (rd_q.cnt != '1) nb.cnt = rd_q.cnt + 1'b1;
      if (ts_q < rd_q.first) begin
        nb.first = ts_q;
        nb.open  = p47;
      end
      if (ts_q >= rd_q.latest) begin
        nb.latest = ts_q;
        nb.close  = p47;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= mem[addr];
    if (cmd_i.upd) begin
      mem[addr] <= nb;
      cur_q[cmd_i.sel] <= nb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      seq_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.upd) valid_q[addr] <= 1'b1;
      if (cmd_i.count) seq_q <= seq_q + 1'b1;
      res_valid_q <= cmd_i.emit_rej || cmd_i.emit_cur || (cmd_i.upd && roll);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_rej) begin
      status_q <= sts_o.bad ? ST_BAD : ST_UNSUP;
      int_q    <= 1'b0;
      fin_q    <= 1'b0;
      res_q    <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.emit_cur) begin
      status_q <= ST_BAR;
      int_q    <= cmd_i.sel;
      fin_q    <= 1'b0;
      res_q    <= cur_q[cmd_i.sel];
      last_q   <= cmd_i.last;
    end else if (cmd_i.upd && roll) begin
      status_q <= ST_BAR;
      int_q    <= cmd_i.sel;
      fin_q    <= 1'b1;
      res_q    <= rd_q;
      last_q   <= 1'b0;
    end
  end

  assign res_valid_o       = res_valid_q;
  assign status_o          = status_q;
  assign interval_sel_o    = int_q;
  assign finalized_o       = fin_q;
  assign bar_o             = res_q;
  assign update_sequence_o = (status_q == ST_BAR) ? seq_q : '0;
  assign last_o            = last_q;

  a_rej_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (status_q != ST_BAR) |-> last_q)
    else $error("reject without last");
  a_upd_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd |-> $past(cmd_i.rd))
    else $error("bar update without fresh read");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !rem_busy)
    else $error("remainder unit restarted while busy");

endmodule

>>> sv/trade_ohlc_bar_aggregator_top.sv
// A rejected trade's report is registered from its check state; an accepted trade's last bar
// report follows both bar updates (finalized bars strobe right after each bar update).
// Start is ignored while busy, so one trade is handled at a time; its busy span is set by the
// three-stage remainder unit and the serialized read and update of the single-port bar memory.
// Results cannot be stalled by the receiver.
// Reset clears valid bits, sequence count and supported mask; bar memory is not cleared.
`timescale 1ns / 1ps
module trade_ohlc_bar_aggregator_top #(
  parameter int unsigned SYMBOLS = toba_pkg::SymbolsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [toba_pkg::PaddrW-1:0]   paddr,
  input  logic [toba_pkg::MaskW-1:0]    pwdata,
  output logic [toba_pkg::MaskW-1:0]    prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [toba_pkg::SymW-1:0]     symbol_index_i,
  input  logic                          ids_present_i,
  input  logic [toba_pkg::TsW-1:0]      timestamp_ms_i,
  input  logic signed [toba_pkg::PxW-1:0] price_i,
  input  logic signed [toba_pkg::PxW-1:0] volume_i,
  output logic                          result_valid_o,
  output logic [1:0]                    status_o,
  output logic                          interval_sel_o,
  output logic                          finalized_o,
  output logic [toba_pkg::TsW-1:0]      bar_start_ms_o,
  output logic [toba_pkg::BarPxW-1:0]   open_price_o,
  output logic [toba_pkg::BarPxW-1:0]   high_price_o,
  output logic [toba_pkg::BarPxW-1:0]   low_price_o,
  output logic [toba_pkg::BarPxW-1:0]   close_price_o,
  output logic [toba_pkg::VolW-1:0]     volume_sum_o,
  output logic [toba_pkg::CntW-1:0]     trade_count_o,
  output logic [toba_pkg::SeqW-1:0]     update_sequence_o,
  output logic                          last_o
);
  import toba_pkg::*;

  logic [MaskW-1:0] mask_q;
  cmd_t cmd;
  sts_t sts;
  bar_t bar;
  logic ctrl_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mask_q <= '0;
    else if (psel && penable && pwrite && (paddr == '0)) mask_q <= pwdata;
  end

  assign pready = 1'b1;
  assign prdata = (paddr == '0) ? mask_q : '0;

  toba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start && !ctrl_busy),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (ctrl_busy)
  );

  toba_dp #(.SYMBOLS(SYMBOLS)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .mask_i            (mask_q),
    .symbol_index_i    (symbol_index_i),
    .ids_present_i     (ids_present_i),
    .timestamp_ms_i    (timestamp_ms_i),
    .price_i           (price_i),
    .volume_i          (volume_i),
    .res_valid_o       (result_valid_o),
    .status_o          (status_o),
    .interval_sel_o    (interval_sel_o),
    .finalized_o       (finalized_o),
    .bar_o             (bar),
    .update_sequence_o (update_sequence_o),
    .last_o            (last_o)
  );

  assign busy           = ctrl_busy;
  assign bar_start_ms_o = bar.start;
  assign open_price_o   = bar.open;
  assign high_price_o   = bar.high;
  assign low_price_o    = bar.low;
  assign close_price_o  = bar.close;
  assign volume_sum_o   = bar.vol;
  assign trade_count_o  = bar.cnt;

endmodule
